>>> src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/dtbi_pkg.sv
`timescale 1ns / 1ps
package dtbi_pkg;

    localparam int ROWS_DEF    = 11;
    localparam int COLS_DEF    = 14;
    localparam int LEVELS_DEF  = 16;

    localparam int FRAC_BITS   = 12;
    localparam int ROW_SPAN    = 10;
    localparam int MACH_SCALE  = 20;
    localparam int MACH_LO_Q   = 4096;
    localparam int MACH_HI_Q   = 57344;

    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 24;
    localparam int LOAD_IDX_W  = 4;
    localparam int VAL_W       = 24;
    localparam int LEVEL_W     = 8;
    localparam int MACH_W      = 16;
    localparam int MS_W        = 21;
    localparam int RQ_W        = 16;
    localparam int IDX_W       = 6;
    localparam int FRAC_W      = 16;
    localparam int DIFF_W      = 25;
    localparam int PROD1_W     = 42;
    localparam int C_W         = 30;
    localparam int PROD2_W     = 47;
    localparam int SUM_W       = 36;
    localparam int NUM_BANKS   = 4;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    typedef struct packed {
        logic                  we;
        logic [LOAD_IDX_W-1:0] row;
        logic [LOAD_IDX_W-1:0] col;
        logic [VAL_W-1:0]      value;
    } load_t;

    typedef struct packed {
        logic              lookup;
        logic [IDX_W-1:0]  ri;
        logic [IDX_W-1:0]  ci;
        logic [FRAC_W-1:0] rf;
        logic [FRAC_W-1:0] cf;
    } look_t;

    typedef struct packed {
        logic              lookup;
        logic              ri0;
        logic              ci0;
        logic [FRAC_W-1:0] rf;
        logic [FRAC_W-1:0] cf;
    } rd_ctl_t;

endpackage

>>> src/dtbi_ram.sv
`timescale 1ns / 1ps
module dtbi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 36
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/dtbi_index.sv
`timescale 1ns / 1ps
module dtbi_index #(
    parameter int ROWS   = dtbi_pkg::ROWS_DEF,
    parameter int COLS   = dtbi_pkg::COLS_DEF,
    parameter int LEVELS = dtbi_pkg::LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic                          in_kind,
    input  logic [dtbi_pkg::S_DATA_W-1:0] in_data,
    output dtbi_pkg::look_t               look,
    output dtbi_pkg::load_t               load
);

    localparam int LEV_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [LEV_IDX_W-1:0] LEV_TOP = LEV_IDX_W'(LEVELS - 1);
    localparam int RI_RAW_W = dtbi_pkg::RQ_W - dtbi_pkg::FRAC_BITS;
    localparam int SUB_W = dtbi_pkg::IDX_W + dtbi_pkg::FRAC_BITS;

    logic [dtbi_pkg::RQ_W-1:0]       rq_tab [LEVELS];
    logic [dtbi_pkg::LOAD_IDX_W-1:0] ld_row;
    logic [dtbi_pkg::LOAD_IDX_W-1:0] ld_col;
    logic [dtbi_pkg::VAL_W-1:0]      ld_value;
    logic [dtbi_pkg::LEVEL_W-1:0]    level;
    logic [dtbi_pkg::MACH_W-1:0]     mach;
    logic [LEV_IDX_W-1:0]            lev_sat;
    logic [dtbi_pkg::RQ_W-1:0]       rq;
    logic [dtbi_pkg::MS_W-1:0]       ms;
    logic [dtbi_pkg::MS_W-1:0]       ms_clamp;
    logic [dtbi_pkg::RQ_W-1:0]       mq;
    logic [dtbi_pkg::IDX_W-1:0]      ri_raw;
    logic [dtbi_pkg::IDX_W-1:0]      ci_raw;
    logic [dtbi_pkg::IDX_W-1:0]      ri;
    logic [dtbi_pkg::IDX_W-1:0]      ci;
    dtbi_pkg::look_t                 look_next;
    dtbi_pkg::load_t                 load_next;
    dtbi_pkg::look_t                 look_reg;
    dtbi_pkg::load_t                 load_reg;

    for (genvar g = 0; g < LEVELS; g++) begin : g_rq
        localparam int RQ_VAL =
            g * dtbi_pkg::ROW_SPAN * (1 << dtbi_pkg::FRAC_BITS) / (LEVELS - 1);
        assign rq_tab[g] = dtbi_pkg::RQ_W'(RQ_VAL);
    end

    // tdata fields
    assign ld_row   = in_data[3:0];
    assign ld_col   = in_data[7:4];
    assign ld_value = in_data[31:8];
    assign level    = in_data[39:32];
    assign mach     = in_data[55:40];

    always_comb begin
        if (level > dtbi_pkg::LEVEL_W'(LEVELS - 1)) begin
            lev_sat = LEV_TOP;
        end else begin
            lev_sat = level[LEV_IDX_W-1:0];
        end
        rq = rq_tab[lev_sat];

        ms = dtbi_pkg::MS_W'(mach) * dtbi_pkg::MS_W'(dtbi_pkg::MACH_SCALE);
        if (ms < dtbi_pkg::MS_W'(dtbi_pkg::MACH_LO_Q)) begin
            ms_clamp = dtbi_pkg::MS_W'(dtbi_pkg::MACH_LO_Q);
        end else if (ms > dtbi_pkg::MS_W'(dtbi_pkg::MACH_HI_Q)) begin
            ms_clamp = dtbi_pkg::MS_W'(dtbi_pkg::MACH_HI_Q);
        end else begin
            ms_clamp = ms;
        end
        mq = dtbi_pkg::RQ_W'(ms_clamp - dtbi_pkg::MS_W'(dtbi_pkg::MACH_LO_Q));

        ri_raw = dtbi_pkg::IDX_W'(rq[dtbi_pkg::RQ_W-1 -: RI_RAW_W]);
        ci_raw = dtbi_pkg::IDX_W'(mq[dtbi_pkg::RQ_W-1 -: RI_RAW_W]);
        if (ri_raw >= dtbi_pkg::IDX_W'(ROWS - 1)) begin
            ri = dtbi_pkg::IDX_W'(ROWS - 2);
        end else begin
            ri = ri_raw;
        end
        if (ci_raw >= dtbi_pkg::IDX_W'(COLS - 1)) begin
            ci = dtbi_pkg::IDX_W'(COLS - 2);
        end else begin
            ci = ci_raw;
        end

        look_next.lookup = in_valid && (in_kind == dtbi_pkg::KIND_LOOKUP);
        look_next.ri     = ri;
        look_next.ci     = ci;
        look_next.rf     = dtbi_pkg::FRAC_W'(SUB_W'(rq) - {ri, {dtbi_pkg::FRAC_BITS{1'b0}}});
        look_next.cf     = dtbi_pkg::FRAC_W'(SUB_W'(mq) - {ci, {dtbi_pkg::FRAC_BITS{1'b0}}});

        load_next.we    = in_valid && (in_kind == dtbi_pkg::KIND_LOAD)
                          && (32'(ld_row) < ROWS) && (32'(ld_col) < COLS);
        load_next.row   = ld_row;
        load_next.col   = ld_col;
        load_next.value = ld_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            look_reg.lookup <= 1'b0;
            load_reg.we     <= 1'b0;
        end else if (en) begin
            look_reg <= look_next;
            load_reg <= load_next;
        end
    end

    assign look = look_reg;
    assign load = load_reg;

endmodule

>>> src/dtbi_lerp.sv
`timescale 1ns / 1ps
module dtbi_lerp (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 en,
    input  dtbi_pkg::rd_ctl_t                                    ctl,
    input  logic [dtbi_pkg::NUM_BANKS-1:0][dtbi_pkg::VAL_W-1:0] bank_rdata,
    output logic                                                 res_valid,
    output logic [dtbi_pkg::VAL_W-1:0]                           res_data
);

    localparam int FB = dtbi_pkg::FRAC_BITS;

    logic [dtbi_pkg::VAL_W-1:0]          v00;
    logic [dtbi_pkg::VAL_W-1:0]          v10;
    logic [dtbi_pkg::VAL_W-1:0]          v01;
    logic [dtbi_pkg::VAL_W-1:0]          v11;
    logic signed [dtbi_pkg::DIFF_W-1:0]  diff0;
    logic signed [dtbi_pkg::DIFF_W-1:0]  diff1;

    logic                                c_valid_reg;
    logic signed [dtbi_pkg::PROD1_W-1:0] p0_reg;
    logic signed [dtbi_pkg::PROD1_W-1:0] p1_reg;
    logic [dtbi_pkg::VAL_W-1:0]          v00_reg;
    logic [dtbi_pkg::VAL_W-1:0]          v01_reg;
    logic [dtbi_pkg::FRAC_W-1:0]         c_cf_reg;
    logic signed [dtbi_pkg::PROD1_W-1:0] p0_next;
    logic signed [dtbi_pkg::PROD1_W-1:0] p1_next;

    logic                                d_valid_reg;
    logic signed [dtbi_pkg::C_W-1:0]     c0_reg;
    logic signed [dtbi_pkg::C_W-1:0]     c1_reg;
    logic [dtbi_pkg::FRAC_W-1:0]         d_cf_reg;
    logic signed [dtbi_pkg::C_W-1:0]     c0_next;
    logic signed [dtbi_pkg::C_W-1:0]     c1_next;

    logic                                e_valid_reg;
    logic signed [dtbi_pkg::C_W-1:0]     e_c0_reg;
    logic signed [dtbi_pkg::C_W-1:0]     d_reg;
    logic [dtbi_pkg::FRAC_W-1:0]         e_cf_reg;
    logic signed [dtbi_pkg::C_W-1:0]     d_next;

    logic                                f_valid_reg;
    logic signed [dtbi_pkg::C_W-1:0]     f_c0_reg;
    logic signed [dtbi_pkg::PROD2_W-1:0] p2_reg;
    logic signed [dtbi_pkg::PROD2_W-1:0] p2_next;

    logic signed [dtbi_pkg::SUM_W-1:0]   sum;

    // banks are indexed by {row parity, column parity}
    always_comb begin
        v00   = bank_rdata[{ctl.ri0, ctl.ci0}];
        v10   = bank_rdata[{~ctl.ri0, ctl.ci0}];
        v01   = bank_rdata[{ctl.ri0, ~ctl.ci0}];
        v11   = bank_rdata[{~ctl.ri0, ~ctl.ci0}];
        diff0 = $signed({1'b0, v10}) - $signed({1'b0, v00});
        diff1 = $signed({1'b0, v11}) - $signed({1'b0, v01});
        p0_next = $signed({1'b0, ctl.rf}) * diff0;
        p1_next = $signed({1'b0, ctl.rf}) * diff1;
    end

    always_comb begin
        c0_next = $signed({{(dtbi_pkg::C_W - dtbi_pkg::VAL_W){1'b0}}, v00_reg})
                  + $signed(p0_reg[dtbi_pkg::PROD1_W-1:FB]);
        c1_next = $signed({{(dtbi_pkg::C_W - dtbi_pkg::VAL_W){1'b0}}, v01_reg})
                  + $signed(p1_reg[dtbi_pkg::PROD1_W-1:FB]);
        d_next  = c1_reg - c0_reg;
        p2_next = $signed({1'b0, e_cf_reg}) * d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= ctl.lookup;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            v00_reg  <= v00;
            v01_reg  <= v01;
            c_cf_reg <= ctl.cf;
            c0_reg   <= c0_next;
            c1_reg   <= c1_next;
            d_cf_reg <= c_cf_reg;
            e_c0_reg <= c0_reg;
            d_reg    <= d_next;
            e_cf_reg <= d_cf_reg;
            f_c0_reg <= e_c0_reg;
            p2_reg   <= p2_next;
        end
    end

    always_comb begin
        sum = dtbi_pkg::SUM_W'(f_c0_reg)
              + dtbi_pkg::SUM_W'($signed(p2_reg[dtbi_pkg::PROD2_W-1:FB]));
        if (sum[dtbi_pkg::SUM_W-1]) begin
            res_data = '0;
        end else if (sum > $signed({{(dtbi_pkg::SUM_W - dtbi_pkg::VAL_W){1'b0}},
                                    dtbi_pkg::VAL_MAX})) begin
            res_data = dtbi_pkg::VAL_MAX;
        end else begin
            res_data = sum[dtbi_pkg::VAL_W-1:0];
        end
    end

    assign res_valid = f_valid_reg;

endmodule

>>> src/dtbi_skid.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtbi_skid #(
    parameter int WIDTH = dtbi_pkg::M_DATA_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             en,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WIDTH-1:0] m_tdata
);

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg;
    logic [WIDTH-1:0] skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        priority if (skid_valid_reg) begin
            if (m_tready) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (out_valid_reg && !m_tready) begin
            if (in_valid) begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else begin
            out_valid_next = in_valid;
            out_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign en       = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_NEVER(a_skid_behind_out, aclk, aresetn, skid_valid_reg && !out_valid_reg, "skid word without output word")

endmodule

>>> src/drag_table_bilinear_interp_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// a lookup reaches m_axis_tvalid through the index register, bank read, lerp stages c to f and
// the skid output register; throughput: one word per cycle while s_axis_tready is high, loads and
// lookups alike; four table banks split by row and column parity give all four corners per read
// a load is visible to any lookup accepted on a later cycle
// reset: synchronous aresetn clears the pipeline and output valids; table contents stay undefined
module drag_table_bilinear_interp_core #(
    parameter int ROWS   = dtbi_pkg::ROWS_DEF,
    parameter int COLS   = dtbi_pkg::COLS_DEF,
    parameter int LEVELS = dtbi_pkg::LEVELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // load_row, load_column, load_value, level, mach
    input  logic [dtbi_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // drag_area
    output logic [dtbi_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int BANK_COLS  = (COLS + 1) / 2;
    localparam int BANK_DEPTH = ((ROWS + 1) / 2) * BANK_COLS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int IW         = dtbi_pkg::IDX_W;

    logic                                                 en;
    dtbi_pkg::look_t                                      a_look;
    dtbi_pkg::load_t                                      a_load;
    dtbi_pkg::rd_ctl_t                                    b_ctl_reg;
    dtbi_pkg::rd_ctl_t                                    b_ctl_next;
    logic [dtbi_pkg::NUM_BANKS-1:0]                       bank_we;
    logic [dtbi_pkg::NUM_BANKS-1:0][dtbi_pkg::VAL_W-1:0] bank_rdata;
    logic                                                 res_valid;
    logic [dtbi_pkg::VAL_W-1:0]                           res_data;
    logic [BANK_AW-1:0]                                   waddr;

    dtbi_index #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .LEVELS (LEVELS)
    ) u_index (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .look     (a_look),
        .load     (a_load)
    );

    assign waddr = BANK_AW'(32'(a_load.row[dtbi_pkg::LOAD_IDX_W-1:1]) * BANK_COLS
                            + 32'(a_load.col[dtbi_pkg::LOAD_IDX_W-1:1]));

    for (genvar p = 0; p < 2; p++) begin : g_row_par
        for (genvar q = 0; q < 2; q++) begin : g_col_par
            logic [IW-1:0]      rsel;
            logic [IW-1:0]      csel;
            logic [BANK_AW-1:0] raddr;

            assign rsel  = (a_look.ri[0] == 1'(p)) ? a_look.ri : a_look.ri + IW'(1);
            assign csel  = (a_look.ci[0] == 1'(q)) ? a_look.ci : a_look.ci + IW'(1);
            assign raddr = BANK_AW'(32'(rsel[IW-1:1]) * BANK_COLS + 32'(csel[IW-1:1]));
            assign bank_we[p*2+q] = en && a_load.we
                                    && (a_load.row[0] == 1'(p)) && (a_load.col[0] == 1'(q));

            dtbi_ram #(
                .WIDTH (dtbi_pkg::VAL_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .aclk  (aclk),
                .we    (bank_we[p*2+q]),
                .waddr (waddr),
                .wdata (a_load.value),
                .re    (en),
                .raddr (raddr),
                .rdata (bank_rdata[p*2+q])
            );
        end
    end

    always_comb begin
        b_ctl_next.lookup = a_look.lookup;
        b_ctl_next.ri0    = a_look.ri[0];
        b_ctl_next.ci0    = a_look.ci[0];
        b_ctl_next.rf     = a_look.rf;
        b_ctl_next.cf     = a_look.cf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctl_reg.lookup <= 1'b0;
        end else if (en) begin
            b_ctl_reg <= b_ctl_next;
        end
    end

    dtbi_lerp u_lerp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ctl        (b_ctl_reg),
        .bank_rdata (bank_rdata),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    dtbi_skid #(
        .WIDTH (dtbi_pkg::M_DATA_W)
    ) u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_data  (res_data),
        .en       (en),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = en;

    `ASSERT_HOLDS(a_one_bank_write, aclk, aresetn, $onehot0(bank_we), "load hits more than one bank")
    `ASSERT_NEVER(a_row_in_range, aclk, aresetn, a_look.lookup && (32'(a_look.ri) > ROWS - 2), "row index past table")
    `ASSERT_NEVER(a_col_in_range, aclk, aresetn, a_look.lookup && (32'(a_look.ci) > COLS - 2), "column index past table")

endmodule
